FILE: hw/rtl/argb_pixel_blend_unit_defines.svh
// Assertion macros shared by the blend unit. Each use expects i_clk and i_rst_n in scope.
`ifndef ARGB_PIXEL_BLEND_UNIT_DEFINES_SVH
`define ARGB_PIXEL_BLEND_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/apb_pkg.sv
`default_nettype none

package apb_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int ALPHA_CH = 3;
    localparam int PIXEL_W  = CHAN_W * NUM_CHAN;

    typedef enum logic [1:0] {
        OP_PREMUL = 2'd0,
        OP_OVER   = 2'd1,
        OP_BLEND  = 2'd2,
        OP_COPY   = 2'd3
    } t_opcode;

    // Computes (x + 127) / 255 as ((x + 128) * 0x10101) >> 24, exact for these ranges.
    function automatic logic [CHAN_W-1:0] div255_round(input logic [16:0] x);
        logic [17:0] z;
        logic [35:0] t;
        z = {1'b0, x} + 18'd128;
        t = {18'd0, z} + {10'd0, z, 8'd0} + {2'd0, z, 16'd0};
        return t[31:24];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/apb_channel.sv
`default_nettype none

module apb_channel (
    input  wire apb_pkg::t_opcode              i_opcode,
    input  wire                                i_keep_src,
    input  wire logic [apb_pkg::CHAN_W-1:0]    i_src,
    input  wire logic [apb_pkg::CHAN_W-1:0]    i_dst,
    input  wire logic [apb_pkg::CHAN_W-1:0]    i_src_alpha,
    output logic      [apb_pkg::CHAN_W-1:0]    o_value,
    output logic                               o_saturated
);

    logic [apb_pkg::CHAN_W-1:0]   inv_alpha;
    logic [2*apb_pkg::CHAN_W-1:0] prod_s;
    logic [2*apb_pkg::CHAN_W-1:0] prod_d;
    logic [2*apb_pkg::CHAN_W:0]   scaled_in;
    logic [apb_pkg::CHAN_W-1:0]   scaled;
    logic [apb_pkg::CHAN_W:0]     over_sum;

    assign inv_alpha = ~i_src_alpha;
    assign prod_s    = {{apb_pkg::CHAN_W{1'b0}}, i_src} * {{apb_pkg::CHAN_W{1'b0}}, i_src_alpha};
    assign prod_d    = {{apb_pkg::CHAN_W{1'b0}}, i_dst} * {{apb_pkg::CHAN_W{1'b0}}, inv_alpha};
    assign over_sum  = {1'b0, i_src} + {1'b0, scaled};
    assign scaled    = apb_pkg::div255_round(scaled_in);

    always_comb begin
        case (i_opcode)
            apb_pkg::OP_PREMUL: scaled_in = {1'b0, prod_s};
            apb_pkg::OP_BLEND:  scaled_in = {1'b0, prod_s} + {1'b0, prod_d};
            default:            scaled_in = {1'b0, prod_d};
        endcase
    end

    always_comb begin
        o_value     = i_dst;
        o_saturated = 1'b0;
        case (i_opcode)
            apb_pkg::OP_PREMUL: begin
                o_value = i_keep_src ? i_src : scaled;
            end
            apb_pkg::OP_OVER: begin
                if (over_sum[apb_pkg::CHAN_W]) begin
                    o_value     = '1;
                    o_saturated = 1'b1;
                end else begin
                    o_value = over_sum[apb_pkg::CHAN_W-1:0];
                end
            end
            apb_pkg::OP_BLEND: begin
                o_value = scaled;
            end
            default: begin
                o_value = i_dst;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/argb_pixel_blend_unit.sv
// ARGB8888 pixel compositor: premultiply, premultiplied over, straight-alpha blend, or
// destination copy, selected per request. It takes one request per clock while o_stall is low
// and returns one result pixel per request, presented on the outputs through one input
// register and one result register with the channel arithmetic between them.
// Each of the four channel lanes has its own pair of 8x8 multipliers, so throughput is one
// pixel every cycle while the output is not stalled; with both registers full and the output
// stalled, o_stall rises.
`default_nettype none
`include "argb_pixel_blend_unit_defines.svh"

module argb_pixel_blend_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire logic [1:0]                     i_opcode,
    input  wire logic [apb_pkg::PIXEL_W-1:0]    i_source_pixel,
    input  wire logic [apb_pkg::PIXEL_W-1:0]    i_destination_pixel,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic      [apb_pkg::PIXEL_W-1:0]    o_result_pixel,
    output logic                                o_saturated
);

    logic                            r_in_valid;
    apb_pkg::t_opcode                r_opcode;
    logic [apb_pkg::PIXEL_W-1:0]     r_src;
    logic [apb_pkg::PIXEL_W-1:0]     r_dst;
    logic                            r_out_valid;
    logic [apb_pkg::PIXEL_W-1:0]     r_result;
    logic                            r_sat;

    logic                            n_in_valid;
    logic                            n_out_valid;
    logic [apb_pkg::PIXEL_W-1:0]     n_result;
    logic                            n_sat;

    logic                            out_adv;
    logic                            in_take;
    logic [apb_pkg::NUM_CHAN-1:0]    chan_sat;

    genvar g;
    generate
        for (g = 0; g < apb_pkg::NUM_CHAN; g++) begin : g_chan
            apb_channel u_chan (
                .i_opcode    (r_opcode),
                .i_keep_src  ((g == apb_pkg::ALPHA_CH) && (r_opcode == apb_pkg::OP_PREMUL)),
                .i_src       (r_src[g*apb_pkg::CHAN_W +: apb_pkg::CHAN_W]),
                .i_dst       (r_dst[g*apb_pkg::CHAN_W +: apb_pkg::CHAN_W]),
                .i_src_alpha (r_src[apb_pkg::ALPHA_CH*apb_pkg::CHAN_W +: apb_pkg::CHAN_W]),
                .o_value     (n_result[g*apb_pkg::CHAN_W +: apb_pkg::CHAN_W]),
                .o_saturated (chan_sat[g])
            );
        end
    endgenerate

    assign n_sat   = |chan_sat;
    assign out_adv = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !out_adv;
    assign in_take = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (out_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (out_adv) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode <= apb_pkg::t_opcode'(i_opcode);
            r_src    <= i_source_pixel;
            r_dst    <= i_destination_pixel;
        end
        if (out_adv && r_in_valid) begin
            r_result <= n_result;
            r_sat    <= n_sat;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_pixel = r_result;
    assign o_saturated    = r_sat;

    `APB_ASSERT_SAME(a_stall_full, o_stall, r_in_valid && r_out_valid, "stall with a free stage")
    `APB_ASSERT_NEXT(a_in_held, r_in_valid && !out_adv, r_in_valid, "input request dropped")
    `APB_ASSERT_NEXT(a_sat_over_only,
        r_in_valid && out_adv && (r_opcode != apb_pkg::OP_OVER),
        !r_sat, "saturation outside over")
    `APB_ASSERT_NEXT(a_opaque_blend,
        r_in_valid && out_adv && (r_opcode == apb_pkg::OP_BLEND) && (r_src[31:24] == 8'hFF),
        r_result == $past(r_src), "opaque blend differs from source")

endmodule

`default_nettype wire

FILE: sim/argb_blend_checker.sv
`timescale 1ns / 100ps

module argb_blend_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [apb_pkg::PIXEL_W-1:0]    i_source_pixel,
    input  logic [apb_pkg::PIXEL_W-1:0]    i_destination_pixel,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_stall,
    input  logic [apb_pkg::PIXEL_W-1:0]    i_result_pixel,
    input  logic                           i_saturated,
    output int                             o_mismatch_count,
    output int                             o_pending_count
);

    typedef struct packed {
        logic [apb_pkg::PIXEL_W-1:0] pixel;
        logic                        saturated;
    } t_blended;

    t_blended expected_pixels[$];

    function automatic t_blended blend_pixel(apb_pkg::t_opcode op,
                                             logic [apb_pkg::PIXEL_W-1:0] src,
                                             logic [apb_pkg::PIXEL_W-1:0] dst);
        t_blended    r;
        int unsigned sa;
        int unsigned inv;
        int unsigned s;
        int unsigned d;
        int unsigned v;
        int          ch;
        r   = '0;
        sa  = src[31:24];
        inv = 255 - sa;
        case (op)
            apb_pkg::OP_PREMUL: begin
                r.pixel[31:24] = src[31:24];
                for (ch = 0; ch < 3; ch++) begin
                    s = src[8*ch +: 8];
                    v = (s * sa + 127) / 255;
                    r.pixel[8*ch +: 8] = v[7:0];
                end
            end
            apb_pkg::OP_OVER: begin
                for (ch = 0; ch < apb_pkg::NUM_CHAN; ch++) begin
                    s = src[8*ch +: 8];
                    d = dst[8*ch +: 8];
                    v = s + (d * inv + 127) / 255;
                    if (v > 255) begin
                        v = 255;
                        r.saturated = 1'b1;
                    end
                    r.pixel[8*ch +: 8] = v[7:0];
                end
            end
            apb_pkg::OP_BLEND: begin
                for (ch = 0; ch < apb_pkg::NUM_CHAN; ch++) begin
                    s = src[8*ch +: 8];
                    d = dst[8*ch +: 8];
                    v = (s * sa + d * inv + 127) / 255;
                    r.pixel[8*ch +: 8] = v[7:0];
                end
            end
            default: begin
                r.pixel = dst;
            end
        endcase
        return r;
    endfunction

    initial begin
        o_mismatch_count = 0;
        o_pending_count  = 0;
    end

    always @(posedge i_clk) begin : watch
        t_blended want;
        int       errors;
        errors = 0;
        if (i_rst_n) begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result pixel %h saturated %b", $time,
                             i_result_pixel, i_saturated);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_result_pixel !== want.pixel) begin
                        $display("%0t: result_pixel expected %h actual %h", $time,
                                 want.pixel, i_result_pixel);
                        errors++;
                    end
                    if (i_saturated !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, i_saturated);
                        errors++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                expected_pixels.push_back(blend_pixel(apb_pkg::t_opcode'(i_opcode),
                                                      i_source_pixel, i_destination_pixel));
            end
            o_mismatch_count <= o_mismatch_count + errors;
            o_pending_count  <= expected_pixels.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [1:0]                  i_opcode = apb_pkg::OP_PREMUL;
    logic [apb_pkg::PIXEL_W-1:0] i_source_pixel = '0;
    logic [apb_pkg::PIXEL_W-1:0] i_destination_pixel = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [apb_pkg::PIXEL_W-1:0] o_result_pixel;
    logic                        o_saturated;

    int mismatch_count;
    int pending_count;
    int requests_sent = 0;

    argb_pixel_blend_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_opcode            (i_opcode),
        .i_source_pixel      (i_source_pixel),
        .i_destination_pixel (i_destination_pixel),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_result_pixel      (o_result_pixel),
        .o_saturated         (o_saturated)
    );

    argb_blend_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (i_valid),
        .i_req_stall         (o_stall),
        .i_opcode            (i_opcode),
        .i_source_pixel      (i_source_pixel),
        .i_destination_pixel (i_destination_pixel),
        .i_rsp_valid         (o_valid),
        .i_rsp_stall         (i_stall),
        .i_result_pixel      (o_result_pixel),
        .i_saturated         (o_saturated),
        .o_mismatch_count    (mismatch_count),
        .o_pending_count     (pending_count)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // The output side stalls at random and, twice, holds off long enough to back up the unit.
    initial begin : output_side
        int holdoff_at;
        int r;
        holdoff_at = 200;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 9);
            if (requests_sent >= holdoff_at && holdoff_at < 1000) begin
                i_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
                holdoff_at += 700;
            end else if (r < 5 || (requests_sent >= 450 && requests_sent < 650)) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else if (r < 9) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    task automatic send_pixel(apb_pkg::t_opcode op, logic [apb_pkg::PIXEL_W-1:0] src,
                              logic [apb_pkg::PIXEL_W-1:0] dst);
        int r;
        int gap;
        r = $urandom_range(0, 9);
        if (requests_sent >= 450 && requests_sent < 650) gap = 0;
        else if (r < 4) gap = 0;
        else if (r < 9) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 30);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_opcode            <= op;
        i_source_pixel      <= src;
        i_destination_pixel <= dst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    initial begin : input_side
        apb_pkg::t_opcode            op;
        logic [apb_pkg::PIXEL_W-1:0] src;
        int                          r;
        int                          n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(apb_pkg::OP_PREMUL, 32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(apb_pkg::OP_PREMUL, 32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(apb_pkg::OP_PREMUL, 32'h00FF_FFFF, 32'h1234_5678);
        send_pixel(apb_pkg::OP_PREMUL, 32'h80FF_0180, 32'hFFFF_FFFF);
        send_pixel(apb_pkg::OP_PREMUL, 32'h7F80_7F01, 32'hA5A5_A5A5);
        send_pixel(apb_pkg::OP_OVER,   32'h00FF_FFFF, 32'hFFFF_FFFF);
        send_pixel(apb_pkg::OP_OVER,   32'h0001_0101, 32'hFFFF_FFFF);
        send_pixel(apb_pkg::OP_OVER,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(apb_pkg::OP_OVER,   32'h0000_0000, 32'h0000_0000);
        send_pixel(apb_pkg::OP_OVER,   32'h8040_2010, 32'h8080_8080);
        send_pixel(apb_pkg::OP_OVER,   32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(apb_pkg::OP_BLEND,  32'hFF12_3456, 32'hFFFF_FFFF);
        send_pixel(apb_pkg::OP_BLEND,  32'h0012_3456, 32'hFEDC_BA98);
        send_pixel(apb_pkg::OP_BLEND,  32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(apb_pkg::OP_BLEND,  32'h80FF_0080, 32'h00FF_FF00);
        send_pixel(apb_pkg::OP_BLEND,  32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(apb_pkg::OP_COPY,   32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(apb_pkg::OP_COPY,   32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(apb_pkg::OP_COPY,   32'h5A5A_5A5A, 32'hC3C3_3C3C);

        for (n = 0; n < 1400; n++) begin
            r = $urandom_range(0, 15);
            if (r < 5) op = apb_pkg::OP_PREMUL;
            else if (r < 10) op = apb_pkg::OP_OVER;
            else if (r < 15) op = apb_pkg::OP_BLEND;
            else op = apb_pkg::OP_COPY;
            src = $urandom;
            if ($urandom_range(0, 3) == 0) src[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            send_pixel(op, src, $urandom);
        end
        i_valid <= 1'b0;

        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
